// File: hw/rtl/bqvg_pkg.sv
// Shared types, constants and helpers for the billboard quad vertex generator.
`timescale 1ns / 1ps

package bqvg_pkg;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_QUAT_X = 3'd0;
    localparam logic [2:0] REG_QUAT_Y = 3'd1;
    localparam logic [2:0] REG_QUAT_Z = 3'd2;
    localparam logic [2:0] REG_QUAT_W = 3'd3;
    localparam logic [2:0] REG_CAM_X  = 3'd4;
    localparam logic [2:0] REG_CAM_Y  = 3'd5;
    localparam logic [2:0] REG_CAM_Z  = 3'd6;

    localparam int ADDR_W = 5;

    // Corner codes, emitted in this order
    localparam logic [1:0] CORNER_TL = 2'd0;  // (-1, 1)
    localparam logic [1:0] CORNER_TR = 2'd1;  // ( 1, 1)
    localparam logic [1:0] CORNER_BR = 2'd2;  // ( 1,-1)
    localparam logic [1:0] CORNER_BL = 2'd3;  // (-1,-1)

    // Q2.14 one, as reset value of quat_w and of the identity basis
    localparam logic signed [15:0] QUAT_ONE  = 16'sd16384;
    localparam logic signed [17:0] BASIS_ONE = 18'sd16384;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } quat_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cam_t;

    // Right and up vectors, Q4.14
    typedef struct packed {
        logic signed [17:0] rx;
        logic signed [17:0] ry;
        logic signed [17:0] rz;
        logic signed [17:0] ux;
        logic signed [17:0] uy;
        logic signed [17:0] uz;
    } basis_t;

    // Clamp a 39-bit sum into signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
        logic signed [38:0] hi;
        logic signed [38:0] lo;
        hi = 39'sh0_7FFF_FFFF;
        lo = -39'sh0_8000_0000;
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

// File: hw/rtl/bqvg_if.sv
// Particle input and vertex output channel interfaces.
`timescale 1ns / 1ps

interface bqvg_particle_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [30:0] size;
    logic        [15:0] red;
    logic        [15:0] green;
    logic        [15:0] blue;
    logic               last_particle;

    modport source (output valid, pos_x, pos_y, pos_z, size, red, green, blue, last_particle,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, size, red, green, blue, last_particle,
                    output ready);
endinterface

interface bqvg_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic        [15:0] red_out;
    logic        [15:0] green_out;
    logic        [15:0] blue_out;
    logic        [1:0]  corner;
    logic               last_corner;
    logic               batch_end;

    modport source (output valid, vert_x, vert_y, vert_z, red_out, green_out, blue_out,
                    corner, last_corner, batch_end, input ready);
    modport sink   (input valid, vert_x, vert_y, vert_z, red_out, green_out, blue_out,
                    corner, last_corner, batch_end, output ready);
endinterface

// File: hw/rtl/bqvg_regs.sv
// APB configuration registers and basis settle timer.
`timescale 1ns / 1ps

module bqvg_regs
    import bqvg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output quat_t             quat,
    output cam_t              cam,
    output logic              settled
);

    // basis pipeline is two registers deep behind the quaternion
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    quat_t      quat_reg;
    cam_t       cam_reg;
    logic [1:0] settle_reg;
    logic [1:0] settle_next;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg <= '{x: 16'sd0, y: 16'sd0, z: 16'sd0, w: QUAT_ONE};
            cam_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_QUAT_X: quat_reg.x <= pwdata[15:0];
                REG_QUAT_Y: quat_reg.y <= pwdata[15:0];
                REG_QUAT_Z: quat_reg.z <= pwdata[15:0];
                REG_QUAT_W: quat_reg.w <= pwdata[15:0];
                REG_CAM_X:  cam_reg.x  <= pwdata;
                REG_CAM_Y:  cam_reg.y  <= pwdata;
                REG_CAM_Z:  cam_reg.z  <= pwdata;
                default:    ;
            endcase
        end
    end

    // hold off particles until the new basis has reached its registers
    always_comb
    begin
        settle_next = settle_reg;
        if (wr_en && (idx == REG_QUAT_X || idx == REG_QUAT_Y ||
                      idx == REG_QUAT_Z || idx == REG_QUAT_W))
            settle_next = SETTLE_CYCLES;
        else if (settle_reg != 2'd0)
            settle_next = settle_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= 2'd0;
        else
            settle_reg <= settle_next;
    end

    always_comb
    begin
        unique case (idx)
            REG_QUAT_X: prdata = {16'd0, quat_reg.x};
            REG_QUAT_Y: prdata = {16'd0, quat_reg.y};
            REG_QUAT_Z: prdata = {16'd0, quat_reg.z};
            REG_QUAT_W: prdata = {16'd0, quat_reg.w};
            REG_CAM_X:  prdata = cam_reg.x;
            REG_CAM_Y:  prdata = cam_reg.y;
            REG_CAM_Z:  prdata = cam_reg.z;
            default:    prdata = 32'd0;
        endcase
    end

    assign quat    = quat_reg;
    assign cam     = cam_reg;
    assign settled = (settle_reg == 2'd0);

endmodule

// File: hw/rtl/bqvg_basis.sv
// Quaternion to right/up basis: product stage then sum/round/saturate stage.
`timescale 1ns / 1ps

module bqvg_basis
    import bqvg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  quat_t  quat,
    output basis_t basis
);

    localparam logic signed [35:0] ONE28 = 36'sd268435456;
    localparam logic signed [35:0] RND14 = 36'sd8192;

    logic signed [31:0] xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, zw_reg, xz_reg, yw_reg, yz_reg, xw_reg;
    basis_t             basis_reg;
    basis_t             basis_next;

    function automatic logic signed [35:0] ext(input logic signed [31:0] v);
        return {{4{v[31]}}, v};
    endfunction

    // round Q.28 (already doubled) to Q.14, clamp to 18 bits
    function automatic logic signed [17:0] term(input logic signed [35:0] v);
        logic signed [35:0] s;
        logic signed [21:0] t;
        s = v + RND14;
        t = s[35:14];
        if (t > 22'sd131071)
            return 18'sd131071;
        else if (t < -22'sd131072)
            return -18'sd131072;
        else
            return t[17:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xx_reg <= '0;
            yy_reg <= '0;
            zz_reg <= '0;
            xy_reg <= '0;
            zw_reg <= '0;
            xz_reg <= '0;
            yw_reg <= '0;
            yz_reg <= '0;
            xw_reg <= '0;
        end
        else
        begin
            xx_reg <= quat.x * quat.x;
            yy_reg <= quat.y * quat.y;
            zz_reg <= quat.z * quat.z;
            xy_reg <= quat.x * quat.y;
            zw_reg <= quat.z * quat.w;
            xz_reg <= quat.x * quat.z;
            yw_reg <= quat.y * quat.w;
            yz_reg <= quat.y * quat.z;
            xw_reg <= quat.x * quat.w;
        end
    end

    always_comb
    begin
        basis_next.rx = term(ONE28 - ((ext(yy_reg) + ext(zz_reg)) <<< 1));
        basis_next.ry = term((ext(xy_reg) - ext(zw_reg)) <<< 1);
        basis_next.rz = term((ext(xz_reg) + ext(yw_reg)) <<< 1);
        basis_next.ux = term((ext(xy_reg) + ext(zw_reg)) <<< 1);
        basis_next.uy = term(ONE28 - ((ext(xx_reg) + ext(zz_reg)) <<< 1));
        basis_next.uz = term((ext(yz_reg) - ext(xw_reg)) <<< 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            basis_reg <= '{rx: BASIS_ONE, ry: 18'sd0, rz: 18'sd0,
                           ux: 18'sd0, uy: BASIS_ONE, uz: 18'sd0};
        else
            basis_reg <= basis_next;
    end

    assign basis = basis_reg;

endmodule

// File: hw/rtl/bqvg_vertex.sv
// Particle holding stage, corner sequencer, multiply stage and output register.
`timescale 1ns / 1ps

module bqvg_vertex
    import bqvg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  basis_t basis,
    input  cam_t   cam,
    input  logic   settled,
    bqvg_particle_if.sink   part_in,
    bqvg_vertex_if.source   vert_out
);

    localparam logic signed [51:0] RND14 = 52'sd8192;

    // holding stage
    logic               p_valid_reg;
    logic signed [31:0] p_pos_reg [3];
    logic        [30:0] p_size_reg;
    logic        [15:0] p_red_reg, p_green_reg, p_blue_reg;
    logic               p_last_reg;
    logic        [1:0]  corner_reg;

    // multiply stage
    logic               m_valid_reg;
    logic signed [51:0] m_prod_reg [3];
    logic signed [32:0] m_rel_reg [3];
    logic        [15:0] m_red_reg, m_green_reg, m_blue_reg;
    logic        [1:0]  m_corner_reg;
    logic               m_last_reg;

    // output register
    logic               o_valid_reg;
    logic signed [31:0] o_vert_reg [3];
    logic        [15:0] o_red_reg, o_green_reg, o_blue_reg;
    logic        [1:0]  o_corner_reg;
    logic               o_lastc_reg;
    logic               o_batch_reg;

    logic               o_adv, m_adv, issue, p_done, in_xfer;
    logic               cx_pos, cy_pos;
    logic signed [17:0] r_vec [3];
    logic signed [17:0] u_vec [3];
    logic signed [31:0] cam_v [3];
    logic signed [19:0] dir   [3];
    logic signed [51:0] prod  [3];
    logic signed [32:0] rel   [3];
    logic signed [51:0] rnd   [3];
    logic signed [38:0] sum   [3];

    assign r_vec[0] = basis.rx;
    assign r_vec[1] = basis.ry;
    assign r_vec[2] = basis.rz;
    assign u_vec[0] = basis.ux;
    assign u_vec[1] = basis.uy;
    assign u_vec[2] = basis.uz;
    assign cam_v[0] = cam.x;
    assign cam_v[1] = cam.y;
    assign cam_v[2] = cam.z;

    assign o_adv   = !o_valid_reg || vert_out.ready;
    assign m_adv   = !m_valid_reg || o_adv;
    assign issue   = p_valid_reg && m_adv;
    assign p_done  = issue && (corner_reg == CORNER_BL);
    assign part_in.ready = settled && (!p_valid_reg || p_done);
    assign in_xfer = part_in.valid && part_in.ready;

    // corner signs: cx positive on TR/BR, cy positive on TL/TR
    assign cx_pos = (corner_reg == CORNER_TR) || (corner_reg == CORNER_BR);
    assign cy_pos = (corner_reg == CORNER_TL) || (corner_reg == CORNER_TR);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dir[k]  = (cx_pos ? 20'(r_vec[k]) : -20'(r_vec[k]))
                    + (cy_pos ? 20'(u_vec[k]) : -20'(u_vec[k]));
            prod[k] = {{32{dir[k][19]}}, dir[k]} * $signed({21'd0, p_size_reg});
            rel[k]  = 33'(p_pos_reg[k]) - 33'(cam_v[k]);
        end
    end

    // holding stage and corner counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            corner_reg  <= CORNER_TL;
        end
        else
        begin
            if (in_xfer)
            begin
                p_valid_reg <= 1'b1;
                corner_reg  <= CORNER_TL;
            end
            else
            begin
                if (p_done)
                    p_valid_reg <= 1'b0;
                if (issue)
                    corner_reg <= corner_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            p_pos_reg[0] <= part_in.pos_x;
            p_pos_reg[1] <= part_in.pos_y;
            p_pos_reg[2] <= part_in.pos_z;
            p_size_reg   <= part_in.size;
            p_red_reg    <= part_in.red;
            p_green_reg  <= part_in.green;
            p_blue_reg   <= part_in.blue;
            p_last_reg   <= part_in.last_particle;
        end
    end

    // multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (m_adv)
            m_valid_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            m_prod_reg   <= prod;
            m_rel_reg    <= rel;
            m_red_reg    <= p_red_reg;
            m_green_reg  <= p_green_reg;
            m_blue_reg   <= p_blue_reg;
            m_corner_reg <= corner_reg;
            m_last_reg   <= p_last_reg;
        end
    end

    // round Q.30 to Q16.16 (signed shift), add, clamp
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rnd[k] = m_prod_reg[k] + RND14;
            sum[k] = 39'(m_rel_reg[k]) + 39'($signed(rnd[k][52-1:14]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (o_adv)
            o_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (o_adv && m_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
                o_vert_reg[k] <= sat32(sum[k]);
            o_red_reg    <= m_red_reg;
            o_green_reg  <= m_green_reg;
            o_blue_reg   <= m_blue_reg;
            o_corner_reg <= m_corner_reg;
            o_lastc_reg  <= (m_corner_reg == CORNER_BL);
            o_batch_reg  <= (m_corner_reg == CORNER_BL) && m_last_reg;
        end
    end

    assign vert_out.valid       = o_valid_reg;
    assign vert_out.vert_x      = o_vert_reg[0];
    assign vert_out.vert_y      = o_vert_reg[1];
    assign vert_out.vert_z      = o_vert_reg[2];
    assign vert_out.red_out     = o_red_reg;
    assign vert_out.green_out   = o_green_reg;
    assign vert_out.blue_out    = o_blue_reg;
    assign vert_out.corner      = o_corner_reg;
    assign vert_out.last_corner = o_lastc_reg;
    assign vert_out.batch_end   = o_batch_reg;

endmodule

// File: hw/rtl/billboard_quad_vertex_gen_top.sv
// Top level of the camera-facing billboard quad vertex generator.
//
//  channel   | dir | handshake      | payload
//  ----------+-----+----------------+-----------------------------------------------
//  part_in   | in  | valid/ready    | pos_x/y/z Q16.16, size, red/green/blue, last_particle
//  vert_out  | out | valid/ready    | vert_x/y/z Q16.16, colors, corner, last_corner,
//            |     |                | batch_end
//  apb       | in  | psel/penable   | quat_x/y/z/w at 0x00-0x0C, cam_x/y/z at 0x10-0x18
//
// Each particle occupies the holding stage for one issue per corner; the corner
// sequencer there issues one vertex per cycle while vert_out is not stalled, so a
// new particle can be taken as its last corner issues and vertices leave back to back.
// A particle passes the holding, multiply and output registers before its first
// vertex is valid. A quaternion write recomputes the basis through a 2-register
// pipeline; particles are held off until the new basis has reached its registers.
// Reset (rst_n, async low) empties all stages and loads the identity
// quaternion, identity basis and a camera at the origin.
// A stalled vert_out holds its vertex; back-pressure ripples back to part_in.
`timescale 1ns / 1ps

module billboard_quad_vertex_gen_top
    import bqvg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    bqvg_particle_if.sink     part_in,
    bqvg_vertex_if.source     vert_out
);

    quat_t  quat;
    cam_t   cam;
    basis_t basis;
    logic   settled;

    // register file; settled drops for the basis pipeline after a quat write
    bqvg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .quat    (quat),
        .cam     (cam),
        .settled (settled)
    );

    // right/up vectors from the quaternion
    bqvg_basis u_basis (
        .clk   (clk),
        .rst_n (rst_n),
        .quat  (quat),
        .basis (basis)
    );

    // per-corner datapath
    bqvg_vertex u_vertex (
        .clk      (clk),
        .rst_n    (rst_n),
        .basis    (basis),
        .cam      (cam),
        .settled  (settled),
        .part_in  (part_in),
        .vert_out (vert_out)
    );

endmodule
